/* src/grey_glyph_color_blend_assert.svh */
// assertion macros used by the checker file
`ifndef GREY_GLYPH_COLOR_BLEND_ASSERT_SVH
`define GREY_GLYPH_COLOR_BLEND_ASSERT_SVH

// same-cycle implication, reset masked
`define GGCB_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, reset masked
`define GGCB_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/ggcb_pkg.sv */
// types and constants of the grey glyph colour blend pipeline
package ggcb_pkg;

    localparam logic [7:0]  COV_NONE = 8'd0;
    localparam logic [7:0]  COV_FULL = 8'd255;

    localparam logic [13:0] SCREEN_WIDTH_RST  = 14'd1024;
    localparam logic [13:0] SCREEN_HEIGHT_RST = 14'd768;
    localparam logic [15:0] ROW_STRIDE_RST    = 16'd4096;

    typedef enum logic [1:0] {
        CFG_SCREEN_WIDTH  = 2'd0,
        CFG_SCREEN_HEIGHT = 2'd1,
        CFG_ROW_STRIDE    = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic [12:0] origin_x;
        logic [12:0] origin_y;
        logic [11:0] glyph_width;
        logic [11:0] glyph_height;
        logic [11:0] sample_col;
        logic [11:0] sample_row;
        logic [7:0]  coverage;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic        end_of_batch;
    } ggcb_in_t;

    typedef struct packed {
        logic        write_enable;
        logic [27:0] byte_offset;
        logic [23:0] pixel_xrgb;
        logic        status;
        logic        batch_done;
    } ggcb_out_t;

    // after clipping, products and screen position
    typedef struct packed {
        logic        write_enable;
        logic        status;
        logic        batch_done;
        logic [13:0] pos_x;
        logic [13:0] pos_y;
        logic        cov_none;
        logic        cov_full;
        logic [23:0] fg_rgb;
        logic [23:0] bg_rgb;
        logic [2:0][15:0] fg_prod;
        logic [2:0][15:0] bg_prod;
    } ggcb_s1_t;

    // after the row multiply and the channel sums
    typedef struct packed {
        logic        write_enable;
        logic        status;
        logic        batch_done;
        logic [13:0] pos_x;
        logic [29:0] row_offset;
        logic [23:0] pixel_xrgb;
    } ggcb_s2_t;

endpackage

/* src/grey_glyph_color_blend.sv */
// grey glyph coverage blend into xrgb8888 pixels with clipping and offset
// throughput: one word per cycle while rsp_ready does not stall the output,
// three register stages with a valid bit each
// stage 1 clips and forms channel products, stage 2 row multiply and blend, stage 3 offset
// reset: asynchronous, clears the stage valid bits and loads 1024, 768 and 4096
// into the screen width, screen height and row stride registers
module grey_glyph_color_blend
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  ggcb_pkg::ggcb_in_t   req,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output ggcb_pkg::ggcb_out_t  rsp,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    logic [13:0] screen_width_reg, screen_width_next;
    logic [13:0] screen_height_reg, screen_height_next;
    logic [15:0] row_stride_reg, row_stride_next;

    logic v1_reg, v1_next;
    logic v2_reg, v2_next;
    logic v3_reg, v3_next;
    logic ready1, ready2, ready3;

    ggcb_pkg::ggcb_s1_t  s1_reg, s1_next;
    ggcb_pkg::ggcb_s2_t  s2_reg, s2_next;
    ggcb_pkg::ggcb_out_t s3_reg, s3_next;

    // configuration
    assign cfg_ready = 1'b1;

    always_comb
    begin
        screen_width_next  = screen_width_reg;
        screen_height_next = screen_height_reg;
        row_stride_next    = row_stride_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                ggcb_pkg::CFG_SCREEN_WIDTH:  screen_width_next  = cfg_data[13:0];
                ggcb_pkg::CFG_SCREEN_HEIGHT: screen_height_next = cfg_data[13:0];
                ggcb_pkg::CFG_ROW_STRIDE:    row_stride_next    = cfg_data;
                default:                     ;
            endcase
        end
    end

    // flow control, each stage frees up when the one after it can take its word
    assign ready3    = !v3_reg || rsp_ready;
    assign ready2    = !v2_reg || ready3;
    assign ready1    = !v1_reg || ready2;
    assign req_ready = ready1;

    assign v1_next = ready1 ? req_valid : v1_reg;
    assign v2_next = ready2 ? v1_reg    : v2_reg;
    assign v3_next = ready3 ? v2_reg    : v3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= ggcb_pkg::SCREEN_WIDTH_RST;
            screen_height_reg <= ggcb_pkg::SCREEN_HEIGHT_RST;
            row_stride_reg    <= ggcb_pkg::ROW_STRIDE_RST;
            v1_reg            <= 1'b0;
            v2_reg            <= 1'b0;
            v3_reg            <= 1'b0;
        end
        else
        begin
            screen_width_reg  <= screen_width_next;
            screen_height_reg <= screen_height_next;
            row_stride_reg    <= row_stride_next;
            v1_reg            <= v1_next;
            v2_reg            <= v2_next;
            v3_reg            <= v3_next;
        end
    end

    // stage 1: origin check, clipping, channel products
    always_comb
    begin
        logic [7:0] cov_inv;
        cov_inv = ggcb_pkg::COV_FULL - req.coverage;
        s1_next.status = ({1'b0, req.origin_x} >= screen_width_reg) ||
                         ({1'b0, req.origin_y} >= screen_height_reg);
        s1_next.pos_x = {1'b0, req.origin_x} + {2'b00, req.sample_col};
        s1_next.pos_y = {1'b0, req.origin_y} + {2'b00, req.sample_row};
        // with the origin on screen, clipping to screen - origin is a bound on the position
        s1_next.write_enable = !s1_next.status &&
                               (req.sample_col < req.glyph_width) &&
                               (req.sample_row < req.glyph_height) &&
                               (s1_next.pos_x < screen_width_reg) &&
                               (s1_next.pos_y < screen_height_reg);
        s1_next.batch_done = req.end_of_batch;
        s1_next.cov_none   = (req.coverage == ggcb_pkg::COV_NONE);
        s1_next.cov_full   = (req.coverage == ggcb_pkg::COV_FULL);
        s1_next.fg_rgb     = req.fg_rgb;
        s1_next.bg_rgb     = req.bg_rgb;
        for (int c = 0; c < 3; c++)
        begin
            s1_next.fg_prod[c] = {8'd0, req.fg_rgb[8*c +: 8]} * {8'd0, req.coverage};
            s1_next.bg_prod[c] = {8'd0, req.bg_rgb[8*c +: 8]} * {8'd0, cov_inv};
        end
    end

    // stage 2: row multiply and blended pixel
    always_comb
    begin
        logic [15:0] sum;
        s2_next.write_enable = s1_reg.write_enable;
        s2_next.status       = s1_reg.status;
        s2_next.batch_done   = s1_reg.batch_done;
        s2_next.pos_x        = s1_reg.pos_x;
        s2_next.row_offset   = {16'd0, s1_reg.pos_y} * {14'd0, row_stride_reg};
        s2_next.pixel_xrgb   = '0;
        sum                  = '0;
        if (!s1_reg.write_enable)
        begin
            s2_next.pixel_xrgb = '0;
        end
        else if (s1_reg.cov_none)
        begin
            s2_next.pixel_xrgb = s1_reg.bg_rgb;
        end
        else if (s1_reg.cov_full)
        begin
            s2_next.pixel_xrgb = s1_reg.fg_rgb;
        end
        else
        begin
            // sum never exceeds 255 * 255, so sixteen bits hold it
            for (int c = 0; c < 3; c++)
            begin
                sum = s1_reg.fg_prod[c] + s1_reg.bg_prod[c];
                s2_next.pixel_xrgb[8*c +: 8] = sum[15:8];
            end
        end
    end

    // stage 3: byte offset, wraps to 28 bits
    always_comb
    begin
        s3_next.write_enable = s2_reg.write_enable;
        s3_next.status       = s2_reg.status;
        s3_next.batch_done   = s2_reg.batch_done;
        s3_next.pixel_xrgb   = s2_reg.pixel_xrgb;
        s3_next.byte_offset  = s2_reg.write_enable ?
                               (s2_reg.row_offset[27:0] + {12'd0, s2_reg.pos_x, 2'b00}) :
                               28'd0;
    end

    always_ff @(posedge clk)
    begin
        if (ready1 && req_valid)
        begin
            s1_reg <= s1_next;
        end
        if (ready2 && v1_reg)
        begin
            s2_reg <= s2_next;
        end
        if (ready3 && v2_reg)
        begin
            s3_reg <= s3_next;
        end
    end

    assign rsp_valid = v3_reg;
    assign rsp       = s3_reg;

endmodule

/* src/ggcb_checker.sv */
// port checker for the grey glyph colour blend, bound to the top level
`include "grey_glyph_color_blend_assert.svh"

module ggcb_checker
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_ready,
    input  logic                 rsp_valid,
    input  logic                 rsp_ready,
    input  ggcb_pkg::ggcb_out_t  rsp
);

    `GGCB_ASSERT_NOW(a_write_needs_ok, rsp_valid && rsp.write_enable, !rsp.status, "write with error status")
    `GGCB_ASSERT_NOW(a_no_write_zero, rsp_valid && !rsp.write_enable, (rsp.byte_offset == 28'd0) && (rsp.pixel_xrgb == 24'd0), "no-write word carries data")
    `GGCB_ASSERT_NOW(a_empty_takes, !rsp_valid, req_ready, "empty output but input refused")
    `GGCB_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "stalled word changed")

endmodule

bind grey_glyph_color_blend ggcb_checker u_ggcb_checker
(
    .clk       (clk),
    .rst_n     (rst_n),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);
